FILE: rtl/adsp_pkg.sv
`timescale 1ns / 1ps
// Package for the alternating dash splitter: constants, register indexes and the
// command and status structs between controller and datapath. No dependencies.
package adsp_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int DASH_W         = 10;
  localparam int CARRY_W        = 12;
  localparam int CUT_W          = 6;
  localparam logic [DASH_W-1:0] MIN_DASH  = 10'd64;
  localparam logic [DASH_W-1:0] DASH_RST  = 10'd256;
  localparam logic [CUT_W-1:0]  MAX_CUTS  = 6'd62;

  typedef enum logic [0:0] {
    CFG_FIRST  = 1'b0,
    CFG_SECOND = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic accept;
    logic sq_a;
    logic sq_b;
    logic sqrt_step;
    logic dist_load;
    logic carry_upd;
    logic sat;
    logic num_load;
    logic mul_x;
    logic mul_y;
    logic div_step;
    logic qx_store;
    logic qy_store;
    logic cut_emit;
    logic vtx_emit;
  } cmd_t;

  typedef struct packed {
    logic in_start;
    logic it_zero;
    logic len_zero;
    logic dist_ge;
    logic cuts_max;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/adsp_if.sv
`timescale 1ns / 1ps
// Request channel interfaces of the alternating dash splitter: vertices in,
// points out. No dependencies.
interface adsp_in_if #(parameter int COORD_BITS = 11);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vertex_x;
  logic [COORD_BITS-1:0] vertex_y;
  logic                  line_start;
  logic                  line_end;
  modport source (output valid, vertex_x, vertex_y, line_start, line_end, input ready);
  modport sink   (input valid, vertex_x, vertex_y, line_start, line_end, output ready);
endinterface

interface adsp_out_if #(parameter int COORD_BITS = 11);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  pen_select;
  logic                  dash_closes;
  logic                  last_of_run;
  modport source (output valid, point_x, point_y, pen_select, dash_closes, last_of_run,
                  input ready);
  modport sink   (input valid, point_x, point_y, pen_select, dash_closes, last_of_run,
                  output ready);
endinterface

FILE: rtl/adsp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the alternating dash splitter.
// Depends on adsp_pkg for the command and status structs.
module adsp_ctrl
  import adsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SQA   = 11'b00000000010,
    ST_SQB   = 11'b00000000100,
    ST_SQRT  = 11'b00000001000,
    ST_CHECK = 11'b00000010000,
    ST_MULX  = 11'b00000100000,
    ST_DIVX  = 11'b00001000000,
    ST_MULY  = 11'b00010000000,
    ST_DIVY  = 11'b00100000000,
    ST_EMITC = 11'b01000000000,
    ST_EMITV = 11'b10000000000
  } state_t;

  state_t st_r, st_nxt;

  assign in_ready = rst_n && (st_r == ST_IDLE);

  always_comb begin
    cmd    = '0;
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          st_nxt = sts.in_start ? ST_EMITV : ST_SQA;
        end
      end
      ST_SQA: begin
        cmd.sq_a = 1'b1;
        st_nxt = ST_SQB;
      end
      ST_SQB: begin
        cmd.sq_b = 1'b1;
        st_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sts.it_zero) begin
          cmd.dist_load = 1'b1;
          st_nxt = ST_CHECK;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts.len_zero || !sts.dist_ge) begin
          cmd.carry_upd = 1'b1;
          st_nxt = ST_EMITV;
        end else if (sts.cuts_max) begin
          cmd.sat = 1'b1;
          st_nxt = ST_EMITV;
        end else begin
          cmd.num_load = 1'b1;
          st_nxt = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd.mul_x = 1'b1;
        st_nxt = ST_DIVX;
      end
      ST_DIVX: begin
        if (sts.it_zero) begin
          cmd.qx_store = 1'b1;
          st_nxt = ST_MULY;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_MULY: begin
        cmd.mul_y = 1'b1;
        st_nxt = ST_DIVY;
      end
      ST_DIVY: begin
        if (sts.it_zero) begin
          cmd.qy_store = 1'b1;
          st_nxt = ST_EMITC;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMITC: begin
        if (sts.out_free) begin
          cmd.cut_emit = 1'b1;
          st_nxt = ST_CHECK;
        end
      end
      ST_EMITV: begin
        if (sts.out_free) begin
          cmd.vtx_emit = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/adsp_dp.sv
`timescale 1ns / 1ps
// Datapath of the alternating dash splitter: dash registers, shared multiplier,
// iterative square root and divider, distance state and output register. Uses adsp_pkg.
module adsp_dp
  import adsp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [DASH_W-1:0]     cfg_data,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic                  in_start,
  input  logic                  in_end,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  out_pen,
  output logic                  out_closes,
  output logic                  out_last
);

  localparam int CW  = COORD_BITS;
  localparam int RW  = CW + 2;
  localparam int SQW = 2 * RW;
  localparam int PW  = 2 * CW + 3;
  localparam int RMW = RW + 3;
  localparam int DW  = ((RW > CARRY_W) ? RW : CARRY_W) + 1;
  localparam int NW  = DW + 2;
  localparam int ITW = $clog2(PW + 1);

  logic [DASH_W-1:0]  first_r, second_r;
  logic [CW-1:0]      vx_r, vy_r, prev_x_r, prev_y_r, cx_r, cy_r;
  logic               end_r, phase_r;
  logic signed [CW:0] dx_r, dy_r;
  logic [SQW-1:0]     val_r;
  logic [RMW-1:0]     rem_r;
  logic [RW-1:0]      root_r, num_r;
  logic [DW-1:0]      dist_r;
  logic [CARRY_W-1:0] carried_r;
  logic [CUT_W-1:0]   cuts_r;
  logic [PW-1:0]      prod_r;
  logic [ITW-1:0]     it_r;
  logic               out_valid_r, out_pen_r, out_closes_r, out_last_r;
  logic [CW-1:0]      out_x_r, out_y_r;

  logic [DASH_W-1:0]     dsel, dlen;
  logic [CW:0]           ax, ay, ma;
  logic [RW-1:0]         mb;
  logic [PW-1:0]         mul_p;
  logic [RMW-1:0]        rem_sh, trial;
  logic                  sq_ge;
  logic [RW:0]           dv_t;
  logic                  dv_ge;
  logic signed [NW-1:0]  num_s;
  logic                  out_free;

  function automatic logic [CW-1:0] place(input logic [CW-1:0] base,
                                          input logic neg, input logic [CW:0] q);
    logic signed [CW+1:0] qs;
    logic signed [CW+1:0] sum;
    qs  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = $signed({{2{base[CW-1]}}, base}) + qs;
    return sum[CW-1:0];
  endfunction

  assign dsel = phase_r ? second_r : first_r;
  assign dlen = (dsel < MIN_DASH) ? MIN_DASH : dsel;

  assign ax = dx_r[CW] ? (CW+1)'(-dx_r) : dx_r;
  assign ay = dy_r[CW] ? (CW+1)'(-dy_r) : dy_r;
  assign ma = (cmd.sq_b || cmd.mul_y) ? ay : ax;
  assign mb = (cmd.sq_a || cmd.sq_b) ? RW'(ma) : num_r;
  assign mul_p = ma * mb;

  assign rem_sh = {rem_r[RW:0], val_r[SQW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  assign dv_t  = {rem_r[RW-1:0], prod_r[PW-1]};
  assign dv_ge = (dv_t >= {1'b0, root_r});

  assign num_s = $signed(NW'(root_r)) + $signed(NW'(dlen)) - $signed(NW'(dist_r));

  assign out_free = !out_valid_r || out_ready;

  assign sts.in_start = in_start;
  assign sts.it_zero  = (it_r == '0);
  assign sts.len_zero = (root_r == '0);
  assign sts.dist_ge  = (dist_r >= DW'(dlen));
  assign sts.cuts_max = (cuts_r == MAX_CUTS);
  assign sts.out_free = out_free;

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_pen    = out_pen_r;
  assign out_closes = out_closes_r;
  assign out_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= DASH_RST;
      second_r    <= DASH_RST;
      phase_r     <= 1'b0;
      carried_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
      it_r        <= '0;
      cuts_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FIRST:  first_r  <= cfg_data;
          CFG_SECOND: second_r <= cfg_data;
          default:    first_r  <= first_r;
        endcase
      end
      if (cmd.sq_b) begin
        it_r <= ITW'(RW);
      end else if (cmd.mul_x || cmd.mul_y) begin
        it_r <= ITW'(PW);
      end else if (cmd.sqrt_step || cmd.div_step) begin
        it_r <= it_r - 1'b1;
      end
      if (cmd.dist_load) begin
        cuts_r <= '0;
      end else if (cmd.cut_emit) begin
        cuts_r <= cuts_r + 1'b1;
      end
      if (cmd.carry_upd) begin
        carried_r <= dist_r[CARRY_W-1:0];
      end else if (cmd.sat) begin
        carried_r <= CARRY_W'(dlen - 1'b1);
      end
      if (cmd.cut_emit) begin
        phase_r <= ~phase_r;
      end
      if (cmd.vtx_emit) begin
        prev_x_r <= vx_r;
        prev_y_r <= vy_r;
      end
      if (cmd.cut_emit || cmd.vtx_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vx_r  <= in_x;
      vy_r  <= in_y;
      end_r <= in_end;
      dx_r  <= $signed({in_x[CW-1], in_x}) - $signed({prev_x_r[CW-1], prev_x_r});
      dy_r  <= $signed({in_y[CW-1], in_y}) - $signed({prev_y_r[CW-1], prev_y_r});
    end
    if (cmd.sq_a || cmd.mul_x || cmd.mul_y) begin
      prod_r <= mul_p;
    end else if (cmd.div_step) begin
      prod_r <= {prod_r[PW-2:0], dv_ge};
    end
    if (cmd.sq_b) begin
      val_r  <= SQW'(prod_r) + SQW'(mul_p);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      val_r  <= val_r << 2;
      rem_r  <= sq_ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RW-2:0], sq_ge};
    end else if (cmd.mul_x || cmd.mul_y) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= RMW'(dv_ge ? (dv_t - {1'b0, root_r}) : dv_t);
    end
    if (cmd.dist_load) begin
      dist_r <= DW'(carried_r) + DW'(root_r);
    end else if (cmd.cut_emit) begin
      dist_r <= dist_r - DW'(dlen);
    end
    if (cmd.num_load) begin
      num_r <= num_s[NW-1] ? '0 : num_s[RW-1:0];
    end
    if (cmd.qx_store) begin
      cx_r <= place(prev_x_r, dx_r[CW], prod_r[CW:0]);
    end
    if (cmd.qy_store) begin
      cy_r <= place(prev_y_r, dy_r[CW], prod_r[CW:0]);
    end
    if (cmd.cut_emit) begin
      out_x_r      <= cx_r;
      out_y_r      <= cy_r;
      out_pen_r    <= phase_r;
      out_closes_r <= 1'b1;
      out_last_r   <= 1'b0;
    end else if (cmd.vtx_emit) begin
      out_x_r      <= vx_r;
      out_y_r      <= vy_r;
      out_pen_r    <= phase_r;
      out_closes_r <= end_r && (carried_r != '0);
      out_last_r   <= 1'b1;
    end
  end

  a_cut_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cut_emit |=> out_valid_r && out_closes_r && !out_last_r)
    else $error("cut point not presented as a closing point");

  a_vtx_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vtx_emit |=> out_valid_r && out_last_r)
    else $error("vertex not presented as the last point of its request");

  a_num_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.num_load |=> num_r <= root_r)
    else $error("interpolation factor exceeds the segment length");

endmodule

FILE: rtl/alternating_dash_splitter.sv
`timescale 1ns / 1ps
// Top level of the alternating dash splitter: controller and datapath.
// Depends on adsp_pkg, adsp_if, adsp_ctrl and adsp_dp.
//
// Each vertex request is taken only while the block is idle, so one vertex is
// handled at a time. A line-start vertex is accepted and emitted as its own
// point. Any other vertex first forms the sum of squares (ST_SQA, then ST_SQB),
// runs the segment length through a one-bit-per-cycle square root of
// COORD_BITS+2 steps and loads the distance; then, for each dash cut, the
// shared multiplier and the restoring divider work out the x and y positions
// one after the other, and each point waits further while the output register
// is full. Results sit in an output register, so the next vertex may be taken
// while the last point of the previous one still waits.
module alternating_dash_splitter
  import adsp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [DASH_W-1:0]   cfg_data,
  adsp_in_if.sink             in_ch,
  adsp_out_if.source          out_ch
);

  cmd_t cmd;
  sts_t sts;

  adsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  adsp_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_x       (in_ch.vertex_x),
    .in_y       (in_ch.vertex_y),
    .in_start   (in_ch.line_start),
    .in_end     (in_ch.line_end),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_x      (out_ch.point_x),
    .out_y      (out_ch.point_y),
    .out_pen    (out_ch.pen_select),
    .out_closes (out_ch.dash_closes),
    .out_last   (out_ch.last_of_run)
  );

endmodule

FILE: test/adsp_dash_checker.sv
`timescale 1ns / 1ps
// Checker for the alternating dash splitter: watches the vertex and point channels,
// predicts the points of each accepted vertex and compares them. Depends on adsp_pkg.
module adsp_dash_checker
  import adsp_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [DASH_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CW-1:0]     in_x,
  input  logic [CW-1:0]     in_y,
  input  logic              in_start,
  input  logic              in_end,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CW-1:0]     out_x,
  input  logic [CW-1:0]     out_y,
  input  logic              out_pen,
  input  logic              out_closes,
  input  logic              out_last,
  output int                errors,
  output int                outstanding,
  output int                points_seen,
  output int                cuts_seen
);

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          pen;
    logic          closes;
    logic          last;
  } point_t;

  point_t              expected_points[$];
  logic [DASH_W-1:0]   len_first;
  logic [DASH_W-1:0]   len_second;
  logic                pen_second;
  logic [CARRY_W-1:0]  carry;
  longint              prev_x;
  longint              prev_y;

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 40;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint dash_of(logic second);
    longint l;
    l = second ? longint'(len_second) : longint'(len_first);
    return (l < longint'(MIN_DASH)) ? longint'(MIN_DASH) : l;
  endfunction

  task automatic split_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic s, logic e);
    longint vx, vy, dx, dy, len, dist_acc, l, num;
    int     cuts;
    vx = longint'($signed(x));
    vy = longint'($signed(y));
    if (!s) begin
      dx       = vx - prev_x;
      dy       = vy - prev_y;
      len      = int_sqrt(dx * dx + dy * dy);
      dist_acc = longint'(carry) + len;
      if (len != 0) begin
        cuts = 0;
        while (dist_acc >= dash_of(pen_second)) begin
          l = dash_of(pen_second);
          if (cuts == int'(MAX_CUTS)) begin
            dist_acc = l - 1;
            break;
          end
          num = len + l - dist_acc;
          if (num < 0) num = 0;
          expected_points.push_back(point_t'{x: CW'(prev_x + dx * num / len),
                                             y: CW'(prev_y + dy * num / len),
                                             pen: pen_second, closes: 1'b1, last: 1'b0});
          cuts++;
          dist_acc -= l;
          pen_second = ~pen_second;
        end
      end
      carry = dist_acc[CARRY_W-1:0];
    end
    expected_points.push_back(point_t'{x: x, y: y, pen: pen_second,
                                       closes: e && (carry != 0), last: 1'b1});
    prev_x = vx;
    prev_y = vy;
  endtask

  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (!rst_n) begin
      len_first   = DASH_RST;
      len_second  = DASH_RST;
      pen_second  = 1'b0;
      carry       = '0;
      prev_x      = 0;
      prev_y      = 0;
      errors      = 0;
      points_seen = 0;
      cuts_seen   = 0;
      expected_points.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = point_t'{x: out_x, y: out_y, pen: out_pen, closes: out_closes, last: out_last};
        points_seen++;
        if (!out_last) cuts_seen++;
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected point, expected none, actual x=%0d y=%0d pen=%0d",
                   $time, $signed(got.x), $signed(got.y), got.pen);
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.pen !== want.pen ||
              got.closes !== want.closes || got.last !== want.last) begin
            errors++;
            $display("%0t ns: point mismatch, expected x=%0d y=%0d pen=%0d close=%0d last=%0d",
                     $time, $signed(want.x), $signed(want.y), want.pen, want.closes, want.last);
            $display("%0t ns:                 actual   x=%0d y=%0d pen=%0d close=%0d last=%0d",
                     $time, $signed(got.x), $signed(got.y), got.pen, got.closes, got.last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST) len_first = cfg_data;
        else len_second = cfg_data;
      end
      if (in_valid && in_ready) split_vertex(in_x, in_y, in_start, in_end);
    end
    outstanding = expected_points.size();
  end

endmodule

FILE: test/alternating_dash_splitter_tb.sv
`timescale 1ns / 1ps
// Splitter testbench top: clock, reset, vertex and register stimulus, and the verdict.
// Depends on adsp_pkg, adsp_if, alternating_dash_splitter and adsp_dash_checker.
module alternating_dash_splitter_tb;
  import adsp_pkg::*;

  localparam int CW = COORD_BITS_DEF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = CFG_FIRST;
  logic [DASH_W-1:0] cfg_data = '0;
  int                errors, outstanding, points_seen, cuts_seen;
  int                vertices_sent = 0;
  bit                no_idling = 1'b0;
  int                cur_x = 0, cur_y = 0;

  adsp_in_if  #(.COORD_BITS(CW)) in_ch ();
  adsp_out_if #(.COORD_BITS(CW)) out_ch ();

  alternating_dash_splitter #(.COORD_BITS(CW)) i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  adsp_dash_checker #(.CW(CW)) i_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_x(in_ch.vertex_x),
    .in_y(in_ch.vertex_y), .in_start(in_ch.line_start), .in_end(in_ch.line_end),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_x(out_ch.point_x),
    .out_y(out_ch.point_y), .out_pen(out_ch.pen_select), .out_closes(out_ch.dash_closes),
    .out_last(out_ch.last_of_run), .errors(errors), .outstanding(outstanding),
    .points_seen(points_seen), .cuts_seen(cuts_seen)
  );

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!no_idling && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_vertex(int x, int y, bit s, bit e);
    in_ch.valid      <= 1'b1;
    in_ch.vertex_x   <= CW'(x);
    in_ch.vertex_y   <= CW'(y);
    in_ch.line_start <= s;
    in_ch.line_end   <= e;
    do @(posedge clk); while (!in_ch.ready);
    vertices_sent++;
    cur_x = x;
    cur_y = y;
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DASH_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dashes(int first, int second);
    write_reg(CFG_FIRST, first);
    write_reg(CFG_SECOND, second);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int near_coord(int c);
    int v;
    v = c + int'($urandom_range(0, 128)) - 64;
    return (v > 1023) ? 1023 : (v < -1024) ? -1024 : v;
  endfunction

  task automatic random_vertices(int count);
    int done, segs, x, y;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 8) begin
        send_vertex(rand_coord(), rand_coord(), 1'b1, 1'b0);
        segs = int'($urandom_range(1, 6));
        for (int i = 1; i <= segs; i++) begin
          case ($urandom_range(0, 5))
            0, 1, 2: begin
              x = rand_coord();
              y = rand_coord();
            end
            3, 4: begin
              x = near_coord(cur_x);
              y = near_coord(cur_y);
            end
            default: begin
              x = cur_x;
              y = cur_y;
            end
          endcase
          send_vertex(x, y, 1'b0, i == segs);
        end
        done += segs + 1;
      end else begin
        send_vertex(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.vertex_x   = '0;
    in_ch.vertex_y   = '0;
    in_ch.line_start = 1'b0;
    in_ch.line_end   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Exact dash at a line end leaves no remainder; then a vertex without line start.
    send_vertex(0, 0, 1'b1, 1'b0);
    send_vertex(256, 0, 1'b0, 1'b1);
    send_vertex(100, 50, 1'b0, 1'b0);
    send_vertex(-1024, 1023, 1'b1, 1'b0);
    send_vertex(1023, -1024, 1'b0, 1'b0);
    send_vertex(1023, -1024, 1'b0, 1'b0);
    send_vertex(-1024, -1024, 1'b0, 1'b0);
    send_vertex(1023, 1023, 1'b0, 1'b1);
    drain();

    // Build up a long carried distance, then shrink the dashes so the cut falls behind.
    set_dashes(1023, 1023);
    send_vertex(0, 0, 1'b1, 1'b0);
    for (int i = 0; i < 6; i++) begin
      drain();
      if (i_chk.carry >= 900) break;
      send_vertex((i % 2 == 0) ? 600 : 0, 0, 1'b0, 1'b0);
    end
    drain();
    set_dashes(0, 63);
    send_vertex(cur_x + ((cur_x > 0) ? -3 : 3), 4, 1'b0, 1'b0);
    send_vertex(-1024, 1023, 1'b0, 1'b0);
    send_vertex(1023, -1024, 1'b0, 1'b1);
    drain();

    set_dashes(64, 64);
    random_vertices(90);
    drain();
    set_dashes(1023, 1023);
    random_vertices(90);
    drain();
    set_dashes(0, 1023);
    random_vertices(90);
    drain();
    set_dashes($urandom_range(64, 1023), $urandom_range(64, 1023));
    random_vertices(90);
    drain();
    set_dashes($urandom_range(0, 1023), $urandom_range(0, 1023));
    no_idling = 1'b1;
    random_vertices(90);
    drain();

    $display("Sent %0d vertices over eight dash settings; checked %0d points, %0d of them cuts.",
             vertices_sent, points_seen, cuts_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
